FILE: rtl/core/rtfm_pkg.sv
// ----------------------------------------------------------------------------
// rtfm_pkg
// Types and constants shared by the route table first-match lookup unit.
// ----------------------------------------------------------------------------
package rtfm_pkg;

   localparam int ADDR_W  = 32;
   localparam int IFACE_W = 4;
   localparam int INDEX_W = 6;

   // interfaces at or above this number are unknown and give no route
   localparam int IFACE_COUNT = 16;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [ADDR_W-1:0]  prefix;
      logic [ADDR_W-1:0]  mask;
      logic [IFACE_W-1:0] iface;
   } slot_type;

   typedef struct packed {
      logic hit;
      logic iface_ok;
   } match_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

FILE: rtl/core/rtfm_req_if.sv
// ----------------------------------------------------------------------------
// rtfm_req_if
// Request channel: table writes and address lookups.
// ----------------------------------------------------------------------------
interface rtfm_req_if
   import rtfm_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [INDEX_W-1:0] entry_index;
   logic               entry_valid;
   logic [ADDR_W-1:0]  prefix_addr;
   logic [ADDR_W-1:0]  prefix_mask;
   logic [IFACE_W-1:0] egress_iface;
   logic [ADDR_W-1:0]  lookup_addr;

   modport source (
      output valid, opcode, entry_index, entry_valid, prefix_addr, prefix_mask,
             egress_iface, lookup_addr,
      input  ready
   );

   modport sink (
      input  valid, opcode, entry_index, entry_valid, prefix_addr, prefix_mask,
             egress_iface, lookup_addr,
      output ready
   );
endinterface

FILE: rtl/core/rtfm_rsp_if.sv
// ----------------------------------------------------------------------------
// rtfm_rsp_if
// Response channel: one beat per lookup.
// ----------------------------------------------------------------------------
interface rtfm_rsp_if
   import rtfm_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               route_found;
   logic [IFACE_W-1:0] found_iface;
   logic [INDEX_W-1:0] found_index;

   modport source (
      output valid, route_found, found_iface, found_index,
      input  ready
   );

   modport sink (
      input  valid, route_found, found_iface, found_index,
      output ready
   );
endinterface

FILE: rtl/core/rtfm_ram.sv
// ----------------------------------------------------------------------------
// rtfm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rtfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rtfm_match.sv
// ----------------------------------------------------------------------------
// rtfm_match
// Shared compare unit: masks the lookup address with one slot and checks it.
// ----------------------------------------------------------------------------
module rtfm_match
   import rtfm_pkg::*;
(
   input  logic [ADDR_W-1:0] addr,
   input  slot_type          slot,
   output match_type         result
);

   always_comb begin
      result.hit      = slot.valid && ((addr & slot.mask) == slot.prefix);
      result.iface_ok = int'(slot.iface) < IFACE_COUNT;
   end

endmodule

FILE: rtl/core/route_table_first_match_unit.sv
// ----------------------------------------------------------------------------
// route_table_first_match_unit
// Masked IPv4 route table with first-match lookup in slot order.
// ----------------------------------------------------------------------------
// The table sits in one RAM of TABLE_DEPTH slots, valid mark included. After
// reset a clearing pass zeroes every slot; req ready stays low until it ends.
// A write beat gives no response. A lookup beat walks the table through the
// single RAM read port and one compare unit, one slot per cycle while the
// response side is free, and stops at the first valid slot whose masked
// address equals its prefix: each slot is read into the registered RAM
// output and compared there, and the result of the walk is registered as the
// response (on a miss, after the last slot). Lookups are handled one at a
// time and req ready stays low during a walk; a pending response does not block
// new requests, but the walk stalls on every cycle in which an earlier response
// is still waiting to be taken.
// ----------------------------------------------------------------------------
module route_table_first_match_unit
   import rtfm_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   rtfm_req_if.sink    req_ch,
   rtfm_rsp_if.source  rsp_ch
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [IFACE_W-1:0] rsp_iface_ff, rsp_iface_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic               req_fire;
   logic               rsp_fire;
   logic               out_free;
   logic               finish;
   logic               in_range;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   slot_type           wr_slot;
   logic               rd_en;
   logic [$bits(slot_type)-1:0] rd_word;
   slot_type           rd_slot;
   match_type          match;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_vld_ff && rsp_ch.ready;
   assign out_free = !rsp_vld_ff || rsp_ch.ready;
   assign in_range = int'(req_ch.entry_index) < TABLE_DEPTH;
   assign rd_slot  = slot_type'(rd_word);

   assign finish = (state_ff == ST_SCAN) && out_free && cmp_vld_ff &&
                   (match.hit || (cmp_idx_ff == LAST_IDX));

   rtfm_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_en   (rd_en),
      .rd_addr (scan_ff),
      .rd_data (rd_word)
   );

   rtfm_match u_match (
      .addr   (addr_ff),
      .slot   (rd_slot),
      .result (match)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && (req_ch.opcode == OP_LOOKUP)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ch.ready = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = IDX_W'(req_ch.entry_index);
      wr_slot      = '{valid:  req_ch.entry_valid,
                       prefix: req_ch.prefix_addr,
                       mask:   req_ch.prefix_mask,
                       iface:  req_ch.egress_iface};
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_slot = '0;
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            wr_en        = req_ch.valid && (req_ch.opcode == OP_WRITE) && in_range;
         end
         ST_SCAN: begin
            rd_en = out_free;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // walk and response datapath
   always_comb begin
      clr_in       = (state_ff == ST_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      addr_in      = addr_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_found_in = rsp_found_ff;
      rsp_iface_in = rsp_iface_ff;
      rsp_index_in = rsp_index_ff;

      if (req_fire && (req_ch.opcode == OP_LOOKUP)) begin
         scan_in    = '0;
         cmp_vld_in = 1'b0;
         addr_in    = req_ch.lookup_addr;
      end else if ((state_ff == ST_SCAN) && out_free) begin
         scan_in    = (scan_ff == LAST_IDX) ? scan_ff : scan_ff + 1'b1;
         cmp_vld_in = !finish;
         cmp_idx_in = scan_ff;
      end

      if (finish) begin
         rsp_vld_in   = 1'b1;
         rsp_found_in = match.hit && match.iface_ok;
         rsp_iface_in = (match.hit && match.iface_ok) ? rd_slot.iface : '0;
         rsp_index_in = (match.hit && match.iface_ok) ? INDEX_W'(cmp_idx_ff) : '0;
      end else if (rsp_fire) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         scan_ff    <= scan_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff   <= cmp_idx_in;
      addr_ff      <= addr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_iface_ff <= rsp_iface_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.route_found = rsp_found_ff;
   assign rsp_ch.found_iface = rsp_iface_ff;
   assign rsp_ch.found_index = rsp_index_ff;

   // no response can exist before the clearing pass ends
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_vld_ff)
      else $error("response pending during clearing pass");

   // a miss reports zero interface and slot
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_found_ff) |-> (rsp_iface_ff == '0 && rsp_index_ff == '0))
      else $error("miss with non-zero interface or slot");

   // a new response only comes out of a table walk
   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_SCAN))
      else $error("response raised outside a table walk");

   // the walk freezes while the finished response cannot be stored
   a_scan_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && rsp_vld_ff && !rsp_ch.ready) |=>
         ($stable(scan_ff) && $stable(cmp_idx_ff)))
      else $error("table walk moved while output stalled");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the route table first-match lookup unit.
// A queue of table writes and address lookups feeds a falling-edge driver.
// A rising-edge monitor keeps a shadow route table, predicts the first
// matching slot for every lookup beat and checks each response beat against
// the oldest prediction. Both channels idle at random in the first two of three
// phases, and the response side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import rtfm_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_BEATS = 600;
   localparam int PHASE_BEATS  = 220;
   localparam int HOLD_AT      = 2 * PHASE_BEATS + 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic               opcode;
      logic [INDEX_W-1:0] entry_index;
      logic               entry_valid;
      logic [ADDR_W-1:0]  prefix_addr;
      logic [ADDR_W-1:0]  prefix_mask;
      logic [IFACE_W-1:0] egress_iface;
      logic [ADDR_W-1:0]  lookup_addr;
   } req_beat_type;

   typedef struct packed {
      logic               route_found;
      logic [IFACE_W-1:0] found_iface;
      logic [INDEX_W-1:0] found_index;
   } route_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtfm_req_if req_ch ();
   rtfm_rsp_if rsp_ch ();

   route_table_first_match_unit #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // driven signals
   logic         drv_valid = 1'b0;
   req_beat_type drv_beat  = '0;
   logic         rcv_ready = 1'b0;

   assign req_ch.valid        = drv_valid;
   assign req_ch.opcode       = drv_beat.opcode;
   assign req_ch.entry_index  = drv_beat.entry_index;
   assign req_ch.entry_valid  = drv_beat.entry_valid;
   assign req_ch.prefix_addr  = drv_beat.prefix_addr;
   assign req_ch.prefix_mask  = drv_beat.prefix_mask;
   assign req_ch.egress_iface = drv_beat.egress_iface;
   assign req_ch.lookup_addr  = drv_beat.lookup_addr;
   assign rsp_ch.ready        = rcv_ready;

   req_beat_type     beat_queue[$];
   route_result_type route_expect[$];

   // shadow of the route table
   logic               route_valid  [TABLE_DEPTH];
   logic [ADDR_W-1:0]  route_prefix [TABLE_DEPTH];
   logic [ADDR_W-1:0]  route_mask   [TABLE_DEPTH];
   logic [IFACE_W-1:0] route_iface  [TABLE_DEPTH];

   // what the stimulus has written so far, for aiming lookups
   logic               gen_valid  [TABLE_DEPTH];
   logic [ADDR_W-1:0]  gen_prefix [TABLE_DEPTH];
   logic [ADDR_W-1:0]  gen_mask   [TABLE_DEPTH];

   int   beats_in    = 0;
   int   err_count   = 0;
   int   cycle_count = 0;
   int   hold_left   = 0;
   logic hold_done   = 1'b0;
   logic req_taken   = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic route_result_type route_lookup(logic [ADDR_W-1:0] addr);
      route_result_type res;
      res = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (route_valid[i] && ((addr & route_mask[i]) == route_prefix[i])) begin
            if (int'(route_iface[i]) < IFACE_COUNT) begin
               res.route_found = 1'b1;
               res.found_iface = route_iface[i];
               res.found_index = INDEX_W'(i);
            end
            return res;
         end
      end
      return res;
   endfunction

   function automatic int idle_pct(logic sender);
      if (beats_in < PHASE_BEATS)
         return sender ? 12 : 57;
      else if (beats_in < 2 * PHASE_BEATS)
         return sender ? 57 : 12;
      return 0;
   endfunction

   function automatic logic [ADDR_W-1:0] prefix_to_mask(int len);
      logic [ADDR_W-1:0] ones;
      ones = '1;
      if (len == 0)
         return '0;
      return ones << (ADDR_W - len);
   endfunction

   task automatic push_write(int idx, logic vld, logic [ADDR_W-1:0] pfx,
                             logic [ADDR_W-1:0] msk, logic [IFACE_W-1:0] ifc);
      req_beat_type b;
      b.opcode       = OP_WRITE;
      b.entry_index  = INDEX_W'(idx);
      b.entry_valid  = vld;
      b.prefix_addr  = pfx;
      b.prefix_mask  = msk;
      b.egress_iface = ifc;
      b.lookup_addr  = $urandom;
      beat_queue.push_back(b);
      if (idx < TABLE_DEPTH) begin
         gen_valid[idx]  = vld;
         gen_prefix[idx] = pfx;
         gen_mask[idx]   = msk;
      end
   endtask

   task automatic push_lookup(logic [ADDR_W-1:0] addr);
      req_beat_type b;
      b.opcode       = OP_LOOKUP;
      b.entry_index  = INDEX_W'($urandom);
      b.entry_valid  = 1'($urandom);
      b.prefix_addr  = $urandom;
      b.prefix_mask  = $urandom;
      b.egress_iface = IFACE_W'($urandom);
      b.lookup_addr  = addr;
      beat_queue.push_back(b);
   endtask

   task automatic fill_beats();
      int idx;
      int len;
      int pick;
      logic aimed;
      logic [ADDR_W-1:0] msk;
      for (int i = 0; i < TABLE_DEPTH; i++)
         gen_valid[i] = 1'b0;

      // empty table misses
      push_lookup(32'h0000_0000);
      push_lookup(32'hFFFF_FFFF);
      // default route in the last slot
      push_write(TABLE_DEPTH - 1, 1'b1, 32'h0000_0000, 32'h0000_0000, 4'hF);
      push_lookup(32'h0000_0000);
      push_lookup(32'hFFFF_FFFF);
      // host route in the first slot
      push_write(0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0);
      push_lookup(32'hFFFF_FFFF);
      push_lookup(32'hFFFF_FFFE);
      // overlapping prefixes, the lower slot wins, here also the longer one
      push_write(5, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 4'h7);
      push_write(3, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 4'h9);
      push_lookup(32'h0A01_0203);
      push_lookup(32'h0A02_0304);
      // removal
      push_write(3, 1'b0, $urandom, $urandom, IFACE_W'($urandom));
      push_lookup(32'h0A01_0203);
      // prefix with bits outside its mask never matches
      push_write(5, 1'b1, 32'h0A00_00FF, 32'hFF00_0000, 4'h3);
      push_lookup(32'h0A00_00FF);
      push_write(TABLE_DEPTH - 1, 1'b0, 32'h0000_0000, 32'h0000_0000, 4'hF);
      push_lookup(32'h1234_5678);
      push_write(0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0);
      push_lookup(32'hFFFF_FFFF);
      push_write(1, 1'b1, 32'h8000_0000, 32'h8000_0000, 4'hF);
      push_lookup(32'h8000_0001);
      push_lookup(32'h7FFF_FFFF);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if ($urandom_range(99) < 45) begin
            if ($urandom_range(99) < 85) begin
               idx = ($urandom_range(1)) ? $urandom_range(TABLE_DEPTH - 1)
                                         : $urandom_range(15);
               len = $urandom_range(32);
               msk = prefix_to_mask(len);
               push_write(idx, ($urandom_range(9) != 0), $urandom & msk, msk,
                          IFACE_W'($urandom));
            end else begin
               push_write($urandom_range(TABLE_DEPTH - 1), 1'($urandom), $urandom,
                          $urandom, IFACE_W'($urandom));
            end
         end else begin
            aimed = 1'b0;
            if ($urandom_range(99) < 70) begin
               for (int t = 0; t < 8 && !aimed; t++) begin
                  pick = $urandom_range(TABLE_DEPTH - 1);
                  if (gen_valid[pick]) begin
                     push_lookup((gen_prefix[pick] & gen_mask[pick]) |
                                 ($urandom & ~gen_mask[pick]));
                     aimed = 1'b1;
                  end
               end
            end
            if (!aimed)
               push_lookup($urandom);
         end
      end
   endtask

   // request driver
   always @(negedge clock) begin
      logic         nxt_valid;
      req_beat_type nxt_beat;
      nxt_valid = drv_valid;
      nxt_beat  = drv_beat;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!drv_valid || req_taken) begin
         nxt_valid = 1'b0;
         if (beat_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
            nxt_beat  = beat_queue.pop_front();
            nxt_valid = 1'b1;
         end
      end
      drv_valid <= nxt_valid;
      drv_beat  <= nxt_beat;
   end

   // response receiver with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rcv_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rcv_ready <= 1'b0;
      end else if (!hold_done && beats_in >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rcv_ready <= 1'b0;
      end else begin
         rcv_ready <= ($urandom_range(99) >= idle_pct(1'b0));
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      route_result_type got;
      route_result_type want;
      int               slot;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken = 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++)
            route_valid[i] = 1'b0;
      end else begin
         req_taken = drv_valid && req_ch.ready;
         if (req_taken) begin
            beats_in <= beats_in + 1;
            if (drv_beat.opcode == OP_WRITE) begin
               slot = int'(drv_beat.entry_index);
               if (slot < TABLE_DEPTH) begin
                  route_valid[slot]  = drv_beat.entry_valid;
                  route_prefix[slot] = drv_beat.prefix_addr;
                  route_mask[slot]   = drv_beat.prefix_mask;
                  route_iface[slot]  = drv_beat.egress_iface;
               end
            end else begin
               route_expect.push_back(route_lookup(drv_beat.lookup_addr));
            end
         end
         if (rsp_ch.valid && rcv_ready) begin
            got.route_found = rsp_ch.route_found;
            got.found_iface = rsp_ch.found_iface;
            got.found_index = rsp_ch.found_index;
            if (route_expect.size() == 0) begin
               err_count = err_count + 1;
               if (err_count <= MAX_REPORTS)
                  $display("unexpected response beat: found %b iface %0d index %0d",
                           got.route_found, got.found_iface, got.found_index);
            end else begin
               want = route_expect.pop_front();
               if (got.route_found !== want.route_found ||
                   got.found_iface !== want.found_iface ||
                   got.found_index !== want.found_index) begin
                  err_count = err_count + 1;
                  if (err_count <= MAX_REPORTS)
                     $display("response mismatch: found %b/%b iface %0d/%0d index %0d/%0d %s",
                              want.route_found, got.route_found,
                              want.found_iface, got.found_iface,
                              want.found_index, got.found_index,
                              "(expected/actual)");
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      fill_beats();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (beat_queue.size() != 0 || drv_valid)
         @(posedge clock);
      while (route_expect.size() != 0)
         @(posedge clock);
      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (err_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
